// ===== hdl/kfsl_pkg.sv =====
// Shared types and constants for the keyboard FIFO and strobe latch.
// Used by kfsl_keymap and the top level; depends on nothing.
`timescale 1ns / 1ps

package kfsl_pkg;

   localparam int RING_DEPTH_DEF = 32;

   typedef enum logic [1:0] {
      OP_KEY   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_INIT  = 2'd3
   } op_type;

   localparam logic [30:0] KEY_RETURN    = 31'd13;
   localparam logic [30:0] KEY_BACKSPACE = 31'd8;
   localparam logic [30:0] KEY_ESCAPE    = 31'd27;
   localparam logic [30:0] KEY_CAPS      = 31'h40000039;
   localparam logic [30:0] KEY_RIGHT     = 31'h4000004F;
   localparam logic [30:0] KEY_LEFT      = 31'h40000050;
   localparam logic [30:0] KEY_LOWER_A   = 31'd97;
   localparam logic [30:0] KEY_LOWER_Z   = 31'd122;

   localparam logic [6:0] ASCII_CR     = 7'h0D;
   localparam logic [6:0] ASCII_BS     = 7'h08;
   localparam logic [6:0] ASCII_ESC    = 7'h1B;
   localparam logic [6:0] ASCII_NAK    = 7'h15;
   localparam logic [6:0] CTRL_OFFSET  = 7'd96;
   localparam logic [6:0] CASE_OFFSET  = 7'd32;
   localparam logic [7:0] STROBE_MASK  = 8'h7F;

   // Outcome of translating one key event.
   typedef struct packed {
      logic       push;
      logic       caps_toggle;
      logic [6:0] code;
   } keymap_type;

endpackage

// ===== hdl/kfsl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module kfsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/kfsl_keymap.sv =====
// Modifier filter and host keycode to ASCII translation for key events.
// Depends on kfsl_pkg.
`timescale 1ns / 1ps

module kfsl_keymap (
   input  logic [30:0]          key_code,
   input  logic                 shift_down,
   input  logic                 ctrl_down,
   input  logic                 alt_down,
   input  logic                 meta_down,
   input  logic                 enhanced,
   input  logic                 caps_on,
   output kfsl_pkg::keymap_type result
);
   import kfsl_pkg::*;

   logic letter;
   logic dropped;
   logic small_code;

   assign letter     = (key_code >= KEY_LOWER_A) && (key_code <= KEY_LOWER_Z);
   assign dropped    = shift_down || alt_down || meta_down || (ctrl_down && !letter);
   assign small_code = (key_code[30:7] == '0);

   always_comb begin
      result.caps_toggle = !dropped && (key_code == KEY_CAPS);
      result.push        = !dropped;
      result.code        = key_code[6:0];
      priority if (key_code == KEY_RETURN) begin
         result.code = ASCII_CR;
      end else if (key_code == KEY_BACKSPACE) begin
         result.code = ASCII_BS;
      end else if (key_code == KEY_ESCAPE) begin
         result.code = ASCII_ESC;
      end else if (key_code == KEY_RIGHT) begin
         result.code = ASCII_NAK;
      end else if (key_code == KEY_LEFT) begin
         result.code = ASCII_BS;
      end else if (ctrl_down) begin
         result.code = key_code[6:0] - CTRL_OFFSET;
      end else if (letter && (!enhanced || caps_on)) begin
         result.code = key_code[6:0] - CASE_OFFSET;
      end else begin
         // Untranslated codes above the ASCII range are not queued.
         result.push = !dropped && small_code;
      end
   end

endmodule

// ===== hdl/keyboard_fifo_strobe_latch.sv =====
// Top level of the keyboard FIFO and strobe latch.
// Depends on kfsl_pkg, kfsl_ram and kfsl_keymap.
`timescale 1ns / 1ps

// Keyboard interface: key events are filtered, translated to 7-bit ASCII
// and queued in a ring of RING_DEPTH entries (at most RING_DEPTH-1 keys)
// held in a RAM; a data read pops a key into the 8-bit latch with bit 7 as
// the strobe, a strobe clear drops bit 7, and init empties the ring and
// sets caps lock from the machine type. Every transfer gives one result.
// One item is handled at a time: key events, strobe clears, inits and a
// data read on an empty ring go from idle to the finish state; any other
// read passes through the first-read state and, if entries remain, a
// skip walk over the registered RAM read that reads each entry behind the
// popped key (each zero entry skipped, and the non-zero entry that ends
// the walk if any). While a previous result is held by rsp_stall, an
// item waits in the finish state until the result register drains. The
// ring needs no clearing: only keys written since reset or init are read.
module keyboard_fifo_strobe_latch #(
   parameter int RING_DEPTH = kfsl_pkg::RING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [30:0] req_key_code,
   input  logic        req_shift_down,
   input  logic        req_ctrl_down,
   input  logic        req_alt_down,
   input  logic        req_meta_down,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_key_queued
);
   import kfsl_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_FIRST  = 4'b0010,
      ST_SKIP   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_LAST) ? '0 : idx + 1'b1;
   endfunction

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic             caps_ff, caps_in;
   logic             enh_ff, enh_in;
   logic [7:0]       latch_ff, latch_in;
   logic             queued_ff, queued_in;
   logic [6:0]       k_ff, k_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic             rsp_queued_ff, rsp_queued_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_ra;
   logic [6:0]       ram_rd;
   logic [IDX_W-1:0] head_nxt;
   logic             ring_full;
   logic             out_free;
   keymap_type       km;

   kfsl_keymap u_keymap (
      .key_code   (req_key_code),
      .shift_down (req_shift_down),
      .ctrl_down  (req_ctrl_down),
      .alt_down   (req_alt_down),
      .meta_down  (req_meta_down),
      .enhanced   (enh_ff),
      .caps_on    (caps_ff),
      .result     (km)
   );

   kfsl_ram #(
      .WIDTH (7),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (km.code),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign head_nxt  = ring_next(head_ff);
   assign ring_full = (ring_next(tail_ff) == head_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      caps_in       = caps_ff;
      enh_in        = csr_write_en ? csr_write_data : enh_ff;
      latch_in      = latch_ff;
      queued_in     = queued_ff;
      k_in          = k_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      rsp_queued_in = rsp_queued_ff;
      ram_we        = 1'b0;
      ram_ra        = head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               queued_in = 1'b0;
               state_in  = ST_FINISH;
               unique case (op_type'(req_op))
                  OP_KEY: begin
                     caps_in = caps_ff ^ km.caps_toggle;
                     if (km.push && !ring_full) begin
                        ram_we    = 1'b1;
                        tail_in   = ring_next(tail_ff);
                        queued_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     if (head_ff != tail_ff) begin
                        state_in = ST_FIRST;
                     end
                  end
                  OP_CLEAR: begin
                     latch_in = latch_ff & STROBE_MASK;
                  end
                  OP_INIT: begin
                     head_in = '0;
                     tail_in = '0;
                     caps_in = enh_ff;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FIRST: begin
            // Read data is the popped key; then walk past trailing zero entries.
            k_in    = ram_rd;
            head_in = head_nxt;
            if (head_nxt == tail_ff) begin
               if (ram_rd != '0) begin
                  latch_in = {1'b1, ram_rd};
               end
               state_in = ST_FINISH;
            end else begin
               ram_ra   = head_nxt;
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if ((ram_rd == '0) && (head_nxt != tail_ff)) begin
               head_in = head_nxt;
               ram_ra  = head_nxt;
            end else begin
               if (ram_rd == '0) begin
                  head_in = head_nxt;
               end
               if (k_ff != '0) begin
                  latch_in = {1'b1, k_ff};
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = latch_ff;
               rsp_queued_in = queued_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         caps_ff      <= 1'b1;
         enh_ff       <= 1'b1;
         latch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         caps_ff      <= caps_in;
         enh_ff       <= enh_in;
         latch_ff     <= latch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      queued_ff     <= queued_in;
      k_ff          <= k_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_queued_ff <= rsp_queued_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_key_queued = rsp_queued_ff;

   // A key is never written into a full ring.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !ring_full)
      else $error("key written into a full ring");

   // The RAM is written only by key events, never during a pop walk.
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_IDLE))
      else $error("ring written outside idle");

   // The skip walk never reaches past the write pointer.
   a_skip_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SKIP) |-> (head_ff != tail_ff))
      else $error("skip walk ran past tail");

   // A queued key always advances the write pointer by one.
   a_tail_step: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> (tail_ff == ring_next($past(tail_ff))))
      else $error("tail did not advance on push");

endmodule
